@@ hw/rtl/dra_pkg.sv @@
package dra_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef logic [IW-1:0] t_idx;
    typedef logic [CW-1:0] t_cnt;

    localparam t_cnt CNT_ONE   = CW'(1);
    localparam t_cnt CNT_DEPTH = CW'(TABLE_DEPTH);

    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] KIND_EVICT   = 2'd0;
    localparam logic [1:0] KIND_RESERVE = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [1:0] STAT_GRANTED = 2'd0;
    localparam logic [1:0] STAT_DENIED  = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_REMOVED = 2'd0;
    localparam logic [1:0] STAT_ABSENT  = 2'd1;

    typedef struct packed {
        logic [7:0] session;
        logic [2:0] device;
        logic       cap;
        logic [7:0] prio;
    } t_entry;

    typedef struct packed {
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_entry wr_data;
    } t_tbl_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] target;
        logic [1:0] status;
        logic [7:0] prio;
        logic       ctrl_rst;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PURGE,
        S_FINISH
    } t_state;

endpackage

@@ hw/rtl/dra_table.sv @@
module dra_table
    import dra_pkg::*;
(
    input  logic     i_clk,
    input  t_tbl_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/dra_seq.sv @@
module dra_seq
    import dra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [7:0]  i_session_id,
    input  logic [2:0]  i_device_index,
    input  logic        i_has_capability,
    input  logic [7:0]  i_request_priority,
    input  logic        i_collaborative,
    output t_tbl_req    o_req,
    input  t_entry      i_rd_data,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_cnt   r_idx, n_idx;
    t_cnt   r_w, n_w;
    logic   r_dvalid, n_dvalid;
    logic   r_res_valid, n_res_valid;

    logic       r_cmd, n_cmd;
    logic [7:0] r_sid, n_sid;
    logic [2:0] r_dev, n_dev;
    logic       r_cap, n_cap;
    logic [7:0] r_prio, n_prio;
    logic       r_coll, n_coll;
    logic       r_found, n_found;
    logic       r_fcap, n_fcap;
    logic [7:0] r_fprio, n_fprio;
    logic       r_lcap, n_lcap;
    logic [7:0] r_lprio, n_lprio;
    t_result    r_res, n_res;

    logic take;
    logic full;
    logic remove;

    assign take = (r_cap && !r_lcap) ||
                  (r_cap == r_lcap && $signed(r_prio) > $signed(r_lprio));
    assign full = (r_count >= CNT_DEPTH);
    assign remove = (r_cmd == CMD_RELEASE) ? (!r_found && i_rd_data.session == r_sid)
                                           : (i_rd_data.device == r_dev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dvalid    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dvalid    <= n_dvalid;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_w     <= n_w;
        r_cmd   <= n_cmd;
        r_sid   <= n_sid;
        r_dev   <= n_dev;
        r_cap   <= n_cap;
        r_prio  <= n_prio;
        r_coll  <= n_coll;
        r_found <= n_found;
        r_fcap  <= n_fcap;
        r_fprio <= n_fprio;
        r_lcap  <= n_lcap;
        r_lprio <= n_lprio;
        r_res   <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_w         = r_w;
        n_dvalid    = 1'b0;
        n_res_valid = 1'b0;
        n_cmd       = r_cmd;
        n_sid       = r_sid;
        n_dev       = r_dev;
        n_cap       = r_cap;
        n_prio      = r_prio;
        n_coll      = r_coll;
        n_found     = r_found;
        n_fcap      = r_fcap;
        n_fprio     = r_fprio;
        n_lcap      = r_lcap;
        n_lprio     = r_lprio;
        n_res       = r_res;

        o_req.rd_addr = r_idx[IW-1:0];
        o_req.wr_en   = 1'b0;
        o_req.wr_addr = r_w[IW-1:0];
        o_req.wr_data = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_sid   = i_session_id;
                    n_dev   = i_device_index;
                    n_cap   = i_has_capability;
                    n_prio  = i_request_priority;
                    n_coll  = i_collaborative;
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_w     = '0;
                    n_state = (i_command == CMD_RELEASE) ? S_PURGE : S_SCAN;
                end
            end

            S_SCAN: begin
                if (r_idx < r_count) begin
                    n_dvalid = 1'b1;
                    n_idx    = r_idx + CNT_ONE;
                end
                if (r_dvalid && i_rd_data.device == r_dev) begin
                    if (!r_found) begin
                        n_fcap  = i_rd_data.cap;
                        n_fprio = i_rd_data.prio;
                    end
                    n_found = 1'b1;
                    n_lcap  = i_rd_data.cap;
                    n_lprio = i_rd_data.prio;
                end
                if (r_idx >= r_count && !r_dvalid) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_res.kind     = KIND_RESERVE;
                n_res.target   = r_sid;
                n_res.status   = STAT_GRANTED;
                n_res.prio     = r_prio;
                n_res.ctrl_rst = 1'b0;
                n_res.last     = 1'b1;
                o_req.wr_addr  = r_count[IW-1:0];
                o_req.wr_data  = '{session: r_sid, device: r_dev, cap: r_cap, prio: r_prio};
                n_state        = S_IDLE;
                n_res_valid    = 1'b1;
                if (!r_found || (r_coll && r_fcap == r_cap)) begin
                    if (r_found) begin
                        n_res.prio            = r_fprio;
                        o_req.wr_data.prio    = r_fprio;
                    end
                    if (full) begin
                        n_res.status = STAT_FULL;
                    end else begin
                        o_req.wr_en = 1'b1;
                        n_count     = r_count + CNT_ONE;
                    end
                end else if (take) begin
                    n_res_valid = 1'b0;
                    n_idx       = '0;
                    n_w         = '0;
                    n_state     = S_PURGE;
                end else begin
                    n_res.status = STAT_DENIED;
                end
            end

            S_PURGE: begin
                if (r_idx < r_count) begin
                    n_dvalid = 1'b1;
                    n_idx    = r_idx + CNT_ONE;
                end
                if (r_dvalid) begin
                    if (remove) begin
                        if (r_cmd == CMD_RELEASE) begin
                            n_found = 1'b1;
                            n_fprio = i_rd_data.prio;
                        end else begin
                            n_res_valid    = 1'b1;
                            n_res.kind     = KIND_EVICT;
                            n_res.target   = i_rd_data.session;
                            n_res.status   = STAT_GRANTED;
                            n_res.prio     = i_rd_data.prio;
                            n_res.ctrl_rst = 1'b0;
                            n_res.last     = 1'b0;
                        end
                    end else begin
                        o_req.wr_en = 1'b1;
                        n_w         = r_w + CNT_ONE;
                    end
                end
                if (r_idx >= r_count && !r_dvalid) begin
                    n_state = S_FINISH;
                end
            end

            S_FINISH: begin
                n_res_valid  = 1'b1;
                n_res.target = r_sid;
                n_res.last   = 1'b1;
                n_state      = S_IDLE;
                if (r_cmd == CMD_RELEASE) begin
                    n_count        = r_w;
                    n_res.kind     = KIND_RELEASE;
                    n_res.status   = r_found ? STAT_REMOVED : STAT_ABSENT;
                    n_res.prio     = r_found ? r_fprio : 8'd0;
                    n_res.ctrl_rst = 1'b0;
                end else begin
                    o_req.wr_en    = 1'b1;
                    o_req.wr_data  = '{session: r_sid, device: r_dev, cap: r_cap,
                                       prio: r_prio};
                    n_count        = r_w + CNT_ONE;
                    n_res.kind     = KIND_RESERVE;
                    n_res.status   = STAT_GRANTED;
                    n_res.prio     = r_prio;
                    n_res.ctrl_rst = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ hw/rtl/device_reservation_arbiter.sv @@
// Eviction notices come at most one per cycle during the compaction pass over the table.
// busy falls as the final result is registered, and a new transfer can be accepted while
// that result is presented; the block takes no new request while one is in flight.
// Synchronous active-low reset empties the table; results are never stalled.
module device_reservation_arbiter
    import dra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [7:0]        i_session_id,
    input  logic [2:0]        i_device_index,
    input  logic              i_has_capability,
    input  logic signed [7:0] i_request_priority,
    input  logic              i_collaborative,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_target_session,
    output logic [1:0]        o_status,
    output logic signed [7:0] o_assigned_priority,
    output logic              o_controller_reset,
    output logic              o_last
);

    t_tbl_req tbl_req;
    t_entry   rd_data;
    t_result  res;

    dra_table u_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .o_rd_data (rd_data)
    );

    dra_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_session_id       (i_session_id),
        .i_device_index     (i_device_index),
        .i_has_capability   (i_has_capability),
        .i_request_priority (i_request_priority),
        .i_collaborative    (i_collaborative),
        .o_req              (tbl_req),
        .i_rd_data          (rd_data),
        .o_res_valid        (o_valid),
        .o_res              (res)
    );

    assign o_kind              = res.kind;
    assign o_target_session    = res.target;
    assign o_status            = res.status;
    assign o_assigned_priority = res.prio;
    assign o_controller_reset  = res.ctrl_rst;
    assign o_last              = res.last;

endmodule

@@ tb/sv/dra_checker.sv @@
`timescale 1ns / 100ps

module dra_checker
    import dra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_command,
    input  logic [7:0]        i_session_id,
    input  logic [2:0]        i_device_index,
    input  logic              i_has_capability,
    input  logic signed [7:0] i_request_priority,
    input  logic              i_collaborative,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_target_session,
    input  logic [1:0]        i_status,
    input  logic signed [7:0] i_assigned_priority,
    input  logic              i_controller_reset,
    input  logic              i_last,
    output int                o_mismatches,
    output int                o_pending
);

    t_entry  holders [TABLE_DEPTH];
    int      holder_cnt = 0;
    t_result expected_q [$];
    int      mismatches = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic t_result make_result(input logic [1:0] kind, input logic [7:0] target,
                                            input logic [1:0] status, input logic [7:0] prio,
                                            input logic ctrl_rst, input logic last_flag);
        t_result r;
        r.kind     = kind;
        r.target   = target;
        r.status   = status;
        r.prio     = prio;
        r.ctrl_rst = ctrl_rst;
        r.last     = last_flag;
        return r;
    endfunction

    task automatic add_holder(input logic [7:0] sid, input logic [2:0] dev, input logic cap,
                              input logic [7:0] prio);
        holders[holder_cnt].session = sid;
        holders[holder_cnt].device  = dev;
        holders[holder_cnt].cap     = cap;
        holders[holder_cnt].prio    = prio;
        holder_cnt++;
    endtask

    task automatic predict_release(input logic [7:0] sid);
        int         hit;
        logic [7:0] p;
        hit = -1;
        for (int i = 0; i < holder_cnt; i++) begin
            if (hit < 0 && holders[i].session == sid) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            p = holders[hit].prio;
            for (int j = hit; j < holder_cnt - 1; j++) begin
                holders[j] = holders[j + 1];
            end
            holder_cnt--;
            expected_q.push_back(make_result(KIND_RELEASE, sid, STAT_REMOVED, p, 1'b0, 1'b1));
        end else begin
            expected_q.push_back(make_result(KIND_RELEASE, sid, STAT_ABSENT, 8'd0, 1'b0, 1'b1));
        end
    endtask

    task automatic predict_reserve(input logic [7:0] sid, input logic [2:0] dev, input logic cap,
                                   input logic [7:0] prio, input logic coll);
        int         first_idx;
        int         last_idx;
        int         w;
        logic       takeover;
        logic [7:0] fp;
        first_idx = -1;
        last_idx  = -1;
        for (int i = 0; i < holder_cnt; i++) begin
            if (holders[i].device == dev) begin
                if (first_idx < 0) begin
                    first_idx = i;
                end
                last_idx = i;
            end
        end

        if (first_idx < 0) begin
            if (holder_cnt >= TABLE_DEPTH) begin
                expected_q.push_back(make_result(KIND_RESERVE, sid, STAT_FULL, prio, 1'b0, 1'b1));
            end else begin
                add_holder(sid, dev, cap, prio);
                expected_q.push_back(make_result(KIND_RESERVE, sid, STAT_GRANTED, prio, 1'b0, 1'b1));
            end
        end else if (coll && holders[first_idx].cap == cap) begin
            fp = holders[first_idx].prio;
            if (holder_cnt >= TABLE_DEPTH) begin
                expected_q.push_back(make_result(KIND_RESERVE, sid, STAT_FULL, fp, 1'b0, 1'b1));
            end else begin
                add_holder(sid, dev, cap, fp);
                expected_q.push_back(make_result(KIND_RESERVE, sid, STAT_GRANTED, fp, 1'b0, 1'b1));
            end
        end else begin
            takeover = (cap && !holders[last_idx].cap) ||
                       (cap == holders[last_idx].cap &&
                        $signed(prio) > $signed(holders[last_idx].prio));
            if (takeover) begin
                w = 0;
                for (int i = 0; i < holder_cnt; i++) begin
                    if (holders[i].device == dev) begin
                        expected_q.push_back(make_result(KIND_EVICT, holders[i].session,
                                                         2'd0, holders[i].prio, 1'b0, 1'b0));
                    end else begin
                        holders[w] = holders[i];
                        w++;
                    end
                end
                holder_cnt = w;
                add_holder(sid, dev, cap, prio);
                expected_q.push_back(make_result(KIND_RESERVE, sid, STAT_GRANTED, prio, 1'b1, 1'b1));
            end else begin
                expected_q.push_back(make_result(KIND_RESERVE, sid, STAT_DENIED, prio, 1'b0, 1'b1));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            holder_cnt = 0;
            expected_q.delete();
        end else begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing pending, kind", i_kind, -1);
                end else begin
                    want = expected_q.pop_front();
                    if (i_kind != want.kind)
                        report_mismatch("kind", i_kind, want.kind);
                    if (i_target_session != want.target)
                        report_mismatch("target_session", i_target_session, want.target);
                    if (i_status != want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_assigned_priority != want.prio)
                        report_mismatch("assigned_priority", i_assigned_priority,
                                        $signed(want.prio));
                    if (i_controller_reset != want.ctrl_rst)
                        report_mismatch("controller_reset", i_controller_reset, want.ctrl_rst);
                    if (i_last != want.last)
                        report_mismatch("last", i_last, want.last);
                end
            end
            if (i_start && !i_busy) begin
                if (i_command == CMD_RELEASE) begin
                    predict_release(i_session_id);
                end else begin
                    predict_reserve(i_session_id, i_device_index, i_has_capability,
                                    i_request_priority, i_collaborative);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatches;
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import dra_pkg::*;

    localparam int RANDOM_ITEMS = 345;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SETTLE       = 2 * TABLE_DEPTH + 10;

    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              start              = 1'b0;
    logic              busy;
    logic              i_command          = CMD_RESERVE;
    logic [7:0]        i_session_id       = 8'd0;
    logic [2:0]        i_device_index     = 3'd0;
    logic              i_has_capability   = 1'b0;
    logic signed [7:0] i_request_priority = 8'sd0;
    logic              i_collaborative    = 1'b0;
    logic              o_valid;
    logic [1:0]        o_kind;
    logic [7:0]        o_target_session;
    logic [1:0]        o_status;
    logic signed [7:0] o_assigned_priority;
    logic              o_controller_reset;
    logic              o_last;

    int                mismatches;
    int                pending;
    int                quiet_cycles = 0;
    logic              sender_idles = 1'b1;
    logic [7:0]        session_pool [16];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    device_reservation_arbiter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_command           (i_command),
        .i_session_id        (i_session_id),
        .i_device_index      (i_device_index),
        .i_has_capability    (i_has_capability),
        .i_request_priority  (i_request_priority),
        .i_collaborative     (i_collaborative),
        .o_valid             (o_valid),
        .o_kind              (o_kind),
        .o_target_session    (o_target_session),
        .o_status            (o_status),
        .o_assigned_priority (o_assigned_priority),
        .o_controller_reset  (o_controller_reset),
        .o_last              (o_last)
    );

    dra_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_command           (i_command),
        .i_session_id        (i_session_id),
        .i_device_index      (i_device_index),
        .i_has_capability    (i_has_capability),
        .i_request_priority  (i_request_priority),
        .i_collaborative     (i_collaborative),
        .i_valid             (o_valid),
        .i_kind              (o_kind),
        .i_target_session    (o_target_session),
        .i_status            (o_status),
        .i_assigned_priority (o_assigned_priority),
        .i_controller_reset  (o_controller_reset),
        .i_last              (o_last),
        .o_mismatches        (mismatches),
        .o_pending           (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [7:0] sid, input logic [2:0] dev,
                                input logic cap, input logic [7:0] prio, input logic coll);
        int gap;
        gap = sender_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_command          <= cmd;
        i_session_id       <= sid;
        i_device_index     <= dev;
        i_has_capability   <= cap;
        i_request_priority <= prio;
        i_collaborative    <= coll;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int         sent;
        int         mode;
        int         burst_len;
        int         release_pct;
        logic       burst_cap;
        logic       cmd;
        logic [7:0] sid;
        logic [2:0] dev;
        logic       cap;
        logic [7:0] prio;
        logic       coll;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(CMD_RELEASE, 8'h5A, 3'd0, 1'b0, 8'h00, 1'b0);
        send_request(CMD_RESERVE, 8'h00, 3'd0, 1'b0, 8'h80, 1'b0);
        send_request(CMD_RESERVE, 8'hFF, 3'd0, 1'b0, 8'h7F, 1'b0);
        send_request(CMD_RESERVE, 8'h11, 3'd0, 1'b0, 8'h7F, 1'b0);
        send_request(CMD_RESERVE, 8'h12, 3'd0, 1'b1, 8'h80, 1'b1);
        send_request(CMD_RESERVE, 8'h13, 3'd0, 1'b0, 8'h7F, 1'b1);
        send_request(CMD_RELEASE, 8'h12, 3'd7, 1'b1, 8'h55, 1'b1);
        send_request(CMD_RESERVE, 8'h21, 3'd2, 1'b1, 8'hFF, 1'b0);
        // Collaborative joins fill the table on one device; one session reserves twice.
        for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
            sid = (k == 7) ? 8'h21 : 8'(8'h30 + k);
            send_request(CMD_RESERVE, sid, 3'd2, 1'b1, 8'($urandom), 1'b1);
        end
        send_request(CMD_RESERVE, 8'h40, 3'd5, 1'b0, 8'h10, 1'b0);
        send_request(CMD_RESERVE, 8'h41, 3'd2, 1'b1, 8'h10, 1'b1);
        // A higher priority empties the full table in one takeover.
        send_request(CMD_RESERVE, 8'h42, 3'd2, 1'b1, 8'h00, 1'b0);
        drain_results();

        foreach (session_pool[i]) session_pool[i] = 8'($urandom);
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode         = $urandom_range(0, 2);
            burst_len    = $urandom_range(8, 20);
            burst_cap    = 1'($urandom_range(0, 1));
            sender_idles = ($urandom_range(0, 3) != 0);
            release_pct  = (mode == 0) ? 30 : (mode == 1) ? 5 : 70;
            session_pool[$urandom_range(0, 15)] = 8'($urandom);
            for (int n = 0; n < burst_len && sent < RANDOM_ITEMS; n++) begin
                cmd  = ($urandom_range(0, 99) < release_pct) ? CMD_RELEASE : CMD_RESERVE;
                sid  = ($urandom_range(0, 9) < 8) ? session_pool[$urandom_range(0, 15)]
                                                  : 8'($urandom);
                dev  = (mode == 1) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
                cap  = (mode == 1 && $urandom_range(0, 9) != 0) ? burst_cap
                                                                 : 1'($urandom_range(0, 1));
                prio = $urandom_range(0, 1) ? 8'($urandom) : 8'(int'($urandom_range(0, 4)) - 2);
                coll = (mode == 1) ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
                send_request(cmd, sid, dev, cap, prio, coll);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
